// ===== hdl/tlsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsd_pkg
// Shared constants and types for the record deframer.
// ----------------------------------------------------------------------------
package tlsd_pkg;

   localparam int unsigned HEADER_BYTES = 5;

   localparam logic [7:0] TYPE_BYTE    = 8'h17;
   localparam logic [7:0] VERSION_BYTE = 8'h03;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd16384;

   typedef logic [2:0] hdr_pos_type;

   localparam hdr_pos_type HDR_TYPE    = 3'd0;
   localparam hdr_pos_type HDR_VER_MAJ = 3'd1;
   localparam hdr_pos_type HDR_VER_MIN = 3'd2;
   localparam hdr_pos_type HDR_LEN_HI  = 3'd3;
   localparam hdr_pos_type HDR_LEN_LO  = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_TOO_LONG   = 2'd2
   } status_type;

   typedef enum logic {
      CSR_INITIAL_SKIP      = 1'b0,
      CSR_MAX_RECORD_LENGTH = 1'b1
   } csr_index_type;

endpackage

// ===== hdl/tlsd_if.sv =====
// ----------------------------------------------------------------------------
// tlsd_req_if / tlsd_rsp_if
// Valid/ready channels carrying stream bytes in and payload beats out.
// ----------------------------------------------------------------------------
interface tlsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tlsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic       record_last;
   logic [1:0] status;

   modport source (output valid, output payload_byte, output payload_valid,
                   output record_last, output status, input ready);
   modport sink   (input valid, input payload_byte, input payload_valid,
                   input record_last, input status, output ready);
endinterface

// ===== hdl/tls_record_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tls_record_deframer_core
// Strips application-data record framing from a byte stream.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and returns exactly one beat per byte, in
// the next cycle, from a single output register; a new byte is taken
// whenever that register is empty or being drained, so throughput is one
// byte per cycle. Leading bytes set by initial_skip are dropped, then each
// record's 5-byte header (17 03 03, length high, length low) is checked and
// its payload passed through with the final byte marked by record_last. A
// bad header byte or a length above max_record_length sets a sticky status
// that holds until reset; writing initial_skip restarts the skip count at
// once.
module tls_record_deframer_core
   import tlsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   tlsd_req_if.sink           req_chan,
   tlsd_rsp_if.source         rsp_chan,
   input  logic               csr_write_en,
   input  csr_index_type      csr_index,
   input  logic [15:0]        csr_write_data
);

   logic        req_accept;

   logic [15:0] skip_remaining_ff, skip_remaining_in;
   hdr_pos_type header_position_ff, header_position_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] payload_remaining_ff, payload_remaining_in;
   status_type  error_code_ff, error_code_in;
   logic [15:0] max_length_ff, max_length_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_pvalid_ff, rsp_pvalid_in;
   logic        rsp_last_ff, rsp_last_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic [15:0] record_length;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign record_length  = {length_high_ff, req_chan.stream_byte};

   always_comb begin
      skip_remaining_in    = skip_remaining_ff;
      header_position_in   = header_position_ff;
      length_high_in       = length_high_ff;
      payload_remaining_in = payload_remaining_ff;
      error_code_in        = error_code_ff;
      max_length_in        = max_length_ff;
      rsp_byte_in          = 8'h00;
      rsp_pvalid_in        = 1'b0;
      rsp_last_in          = 1'b0;

      if (req_accept) begin
         if (error_code_ff != STATUS_OK) begin
            error_code_in = error_code_ff;
         end else if (skip_remaining_ff != 16'd0) begin
            skip_remaining_in = skip_remaining_ff - 16'd1;
         end else if (payload_remaining_ff != 16'd0) begin
            payload_remaining_in = payload_remaining_ff - 16'd1;
            rsp_byte_in          = req_chan.stream_byte;
            rsp_pvalid_in        = 1'b1;
            rsp_last_in          = (payload_remaining_ff == 16'd1);
         end else begin
            case (header_position_ff)
               HDR_VER_MAJ, HDR_VER_MIN: begin
                  if (req_chan.stream_byte != VERSION_BYTE) begin
                     error_code_in = STATUS_BAD_HEADER;
                  end else begin
                     header_position_in = header_position_ff + 3'd1;
                  end
               end
               HDR_LEN_HI: begin
                  length_high_in     = req_chan.stream_byte;
                  header_position_in = HDR_LEN_LO;
               end
               HDR_LEN_LO: begin
                  header_position_in = HDR_TYPE;
                  if (record_length > max_length_ff) begin
                     error_code_in = STATUS_TOO_LONG;
                  end else begin
                     payload_remaining_in = record_length;
                  end
               end
               default: begin
                  if (req_chan.stream_byte != TYPE_BYTE) begin
                     error_code_in = STATUS_BAD_HEADER;
                  end else begin
                     header_position_in = HDR_VER_MAJ;
                  end
               end
            endcase
         end
      end

      rsp_status_in = error_code_in;

      if (csr_write_en) begin
         case (csr_index)
            CSR_INITIAL_SKIP:      skip_remaining_in = csr_write_data;
            CSR_MAX_RECORD_LENGTH: max_length_in     = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_remaining_ff    <= 16'd0;
         header_position_ff   <= HDR_TYPE;
         length_high_ff       <= 8'h00;
         payload_remaining_ff <= 16'd0;
         error_code_ff        <= STATUS_OK;
         max_length_ff        <= MAX_LENGTH_RESET;
         rsp_valid_ff         <= 1'b0;
      end else begin
         skip_remaining_ff    <= skip_remaining_in;
         header_position_ff   <= header_position_in;
         length_high_ff       <= length_high_in;
         payload_remaining_ff <= payload_remaining_in;
         error_code_ff        <= error_code_in;
         max_length_ff        <= max_length_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_pvalid_ff <= rsp_pvalid_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.payload_byte  = rsp_byte_ff;
   assign rsp_chan.payload_valid = rsp_pvalid_ff;
   assign rsp_chan.record_last   = rsp_last_ff;
   assign rsp_chan.status        = rsp_status_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pvalid_ff |-> rsp_status_ff == STATUS_OK)
      else $error("payload beat carries an error status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_pvalid_ff)
      else $error("record_last on a non-payload beat");

   assert property (@(posedge clock) disable iff (reset)
      error_code_ff != STATUS_OK |=> error_code_ff == $past(error_code_ff))
      else $error("sticky error changed");

   assert property (@(posedge clock) disable iff (reset)
      payload_remaining_ff != 16'd0 |-> header_position_ff == HDR_TYPE)
      else $error("payload in progress with a partial header");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted byte produced no beat");
`endif

endmodule
